// File: design/oat_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the ordered array table.
`timescale 1ns / 1ps

package oat_pkg;

    // Table geometry
    localparam int DEPTH  = 16;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WIDE_W = CNT_W + 4;

    // Operation codes
    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_READ    = 3'd1;
    localparam logic [2:0] OP_INSERT  = 3'd2;
    localparam logic [2:0] OP_DELETE  = 3'd3;
    localparam logic [2:0] OP_SEARCH  = 3'd4;
    localparam logic [2:0] OP_REVERSE = 3'd5;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the accepted word, clear the result
        logic set_range;   // flag a bad position
        logic set_full;    // flag a full table
        logic wr_val_cnt;  // write the item value at the end of the table
        logic wr_val_pos;  // write the item value at the item position
        logic cnt_inc;
        logic cnt_dec;
        logic rd_pos;      // read the entry at the item position
        logic cap_read;    // keep the entry read as the result value
        logic start;       // set up pointers for a shift, search or reverse
        logic rd_move;     // read one entry of a shift and advance
        logic rd_search;   // read one entry of a search and advance
        logic rd_hi;       // read the upper entry of a swap pair
        logic cap_tmp;     // hold the lower entry of a swap pair
        logic wr_swap;     // write the lower entry of a swap pair and advance
        logic publish;     // move the result into the output register
    } oat_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [2:0] op;
        logic       pos_ge_cnt;
        logic       pos_gt_cnt;
        logic       pos_last;
        logic       full;
        logic       cnt_zero;
        logic       cnt_le1;
        logic       ptr_at_end;
        logic       hit;
        logic       rev_more;
        logic       out_free;
    } oat_sts_t;

endpackage

// File: design/oat_req_if.sv
// Request channel: operation words into the table.
`timescale 1ns / 1ps

interface oat_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [3:0]         position;
    logic signed [31:0] value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

// File: design/oat_rsp_if.sv
// Response channel: one result word per operation.
`timescale 1ns / 1ps

interface oat_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic               found;
    logic [3:0]         found_index;
    logic [4:0]         entry_count;
    logic [1:0]         status;

    modport source (output valid, output read_value, output found, output found_index,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input read_value, input found, input found_index,
                    input entry_count, input status, output ready);
endinterface

// File: design/oat_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module oat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/oat_dp.sv
// Datapath: item registers, count, pointers, entry store and result registers.
`timescale 1ns / 1ps

module oat_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  oat_pkg::oat_cmd_t   cmd,
    output oat_pkg::oat_sts_t   sts,
    input  logic [2:0]          opcode,
    input  logic [3:0]          position,
    input  logic signed [31:0]  value,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic signed [31:0]  read_value,
    output logic                found,
    output logic [3:0]          found_index,
    output logic [4:0]          entry_count,
    output logic [1:0]          status
);

    localparam int AW = oat_pkg::AW;
    localparam int CW = oat_pkg::CNT_W;
    localparam int WW = oat_pkg::WIDE_W;

    // Item registers
    logic [2:0]         op_reg, op_next;
    logic [3:0]         pos_reg, pos_next;
    logic signed [31:0] val_reg, val_next;

    // Table state and walk pointers
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [AW-1:0]      end_reg, end_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      wb_addr_reg, wb_addr_next;
    logic               mv_pend_reg, mv_pend_next;
    logic               sw_pend_reg, sw_pend_next;
    logic [31:0]        tmp_reg, tmp_next;
    logic               cmp_pend_reg, cmp_pend_next;
    logic [AW-1:0]      cmp_idx_reg, cmp_idx_next;

    // Result under construction
    logic signed [31:0] res_rd_reg, res_rd_next;
    logic               res_found_reg, res_found_next;
    logic [AW-1:0]      res_idx_reg, res_idx_next;
    logic [1:0]         res_st_reg, res_st_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_rd_reg, out_rd_next;
    logic               out_found_reg, out_found_next;
    logic [3:0]         out_idx_reg, out_idx_next;
    logic [4:0]         out_cnt_reg, out_cnt_next;
    logic [1:0]         out_st_reg, out_st_next;

    // Entry store ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;

    // Widened copies for comparisons
    logic [WW-1:0]      pos_w;
    logic [WW-1:0]      cnt_w;
    logic [WW-1:0]      cnt_m1_w;
    logic [WW-1:0]      pos_p1_w;
    logic [WW-1:0]      idx_w;

    assign pos_w    = WW'(pos_reg);
    assign cnt_w    = WW'(count_reg);
    assign cnt_m1_w = cnt_w - WW'(1);
    assign pos_p1_w = pos_w + WW'(1);
    assign idx_w    = WW'(res_idx_reg);

    // Status towards the controller
    assign sts.op         = op_reg;
    assign sts.pos_ge_cnt = (pos_w >= cnt_w);
    assign sts.pos_gt_cnt = (pos_w > cnt_w);
    assign sts.pos_last   = (pos_p1_w == cnt_w);
    assign sts.full       = (cnt_w == WW'(oat_pkg::DEPTH));
    assign sts.cnt_zero   = (cnt_w == '0);
    assign sts.cnt_le1    = (cnt_w <= WW'(1));
    assign sts.ptr_at_end = (ptr_reg == end_reg);
    assign sts.hit        = cmp_pend_reg && (ram_rdata == val_reg);
    assign sts.rev_more   = ((WW'(ptr_reg) + WW'(2)) < WW'(hi_reg));
    assign sts.out_free   = !out_valid_reg || rsp_ready;

    // Read address: item position, upper swap entry, or the walk pointer
    always_comb
    begin
        if (cmd.rd_pos)
        begin
            ram_raddr = pos_w[AW-1:0];
        end
        else if (cmd.rd_hi)
        begin
            ram_raddr = hi_reg;
        end
        else
        begin
            ram_raddr = ptr_reg;
        end
    end

    // Write port: pending shift or swap write-backs first, then direct writes
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wb_addr_reg;
        ram_wdata = ram_rdata;
        if (mv_pend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (sw_pend_reg)
        begin
            ram_we    = 1'b1;
            ram_wdata = tmp_reg;
        end
        else if (cmd.wr_swap)
        begin
            ram_we    = 1'b1;
            ram_waddr = ptr_reg;
        end
        else if (cmd.wr_val_cnt)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_w[AW-1:0];
            ram_wdata = val_reg;
        end
        else if (cmd.wr_val_pos)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_w[AW-1:0];
            ram_wdata = val_reg;
        end
    end

    oat_ram #(
        .WIDTH (32),
        .DEPTH (oat_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next-state logic for all datapath registers
    always_comb
    begin
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        hi_next        = hi_reg;
        wb_addr_next   = wb_addr_reg;
        mv_pend_next   = cmd.rd_move;
        sw_pend_next   = cmd.wr_swap;
        tmp_next       = tmp_reg;
        cmp_pend_next  = cmd.rd_search;
        cmp_idx_next   = cmp_idx_reg;
        res_rd_next    = res_rd_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_found_next = out_found_reg;
        out_idx_next   = out_idx_reg;
        out_cnt_next   = out_cnt_reg;
        out_st_next    = out_st_reg;

        // Capture the accepted word and clear the result
        if (cmd.load)
        begin
            op_next        = opcode;
            pos_next       = position;
            val_next       = value;
            res_rd_next    = '0;
            res_found_next = 1'b0;
            res_idx_next   = '0;
            res_st_next    = oat_pkg::STAT_OK;
        end

        if (cmd.set_range)
        begin
            res_st_next = oat_pkg::STAT_RANGE;
        end
        if (cmd.set_full)
        begin
            res_st_next = oat_pkg::STAT_FULL;
        end

        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end

        if (cmd.cap_read)
        begin
            res_rd_next = ram_rdata;
        end

        // Keep the first match only
        if (sts.hit && !res_found_reg)
        begin
            res_found_next = 1'b1;
            res_idx_next   = cmp_idx_reg;
        end

        // Set up the walk for the latched operation
        if (cmd.start)
        begin
            unique case (op_reg)
                oat_pkg::OP_INSERT:
                begin
                    ptr_next = cnt_m1_w[AW-1:0];
                    end_next = pos_w[AW-1:0];
                end
                oat_pkg::OP_DELETE:
                begin
                    ptr_next = pos_p1_w[AW-1:0];
                    end_next = cnt_m1_w[AW-1:0];
                end
                default:
                begin
                    ptr_next = '0;
                    end_next = cnt_m1_w[AW-1:0];
                    hi_next  = cnt_m1_w[AW-1:0];
                end
            endcase
        end

        // Shift: insert walks down and writes one place up, delete the reverse
        if (cmd.rd_move)
        begin
            if (op_reg == oat_pkg::OP_INSERT)
            begin
                ptr_next     = ptr_reg - AW'(1);
                wb_addr_next = ptr_reg + AW'(1);
            end
            else
            begin
                ptr_next     = ptr_reg + AW'(1);
                wb_addr_next = ptr_reg - AW'(1);
            end
        end

        // Search: remember which index the compare belongs to
        if (cmd.rd_search)
        begin
            cmp_idx_next = ptr_reg;
            ptr_next     = ptr_reg + AW'(1);
        end

        // Swap: hold the lower entry, then close in from both ends
        if (cmd.cap_tmp)
        begin
            tmp_next = ram_rdata;
        end
        if (cmd.wr_swap)
        begin
            wb_addr_next = hi_reg;
            ptr_next     = ptr_reg + AW'(1);
            hi_next      = hi_reg - AW'(1);
        end

        // Output register: load on publish, drop once taken
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
            out_rd_next    = res_rd_reg;
            out_found_next = res_found_reg;
            out_idx_next   = idx_w[3:0];
            out_cnt_next   = cnt_w[4:0];
            out_st_next    = res_st_reg;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mv_pend_reg   <= 1'b0;
            sw_pend_reg   <= 1'b0;
            cmp_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            mv_pend_reg   <= mv_pend_next;
            sw_pend_reg   <= sw_pend_next;
            cmp_pend_reg  <= cmp_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        ptr_reg       <= ptr_next;
        end_reg       <= end_next;
        hi_reg        <= hi_next;
        wb_addr_reg   <= wb_addr_next;
        tmp_reg       <= tmp_next;
        cmp_idx_reg   <= cmp_idx_next;
        res_rd_reg    <= res_rd_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        res_st_reg    <= res_st_next;
        out_rd_reg    <= out_rd_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
        out_cnt_reg   <= out_cnt_next;
        out_st_reg    <= out_st_next;
    end

    assign rsp_valid   = out_valid_reg;
    assign read_value  = out_rd_reg;
    assign found       = out_found_reg;
    assign found_index = out_idx_reg;
    assign entry_count = out_cnt_reg;
    assign status      = out_st_reg;

endmodule

// File: design/oat_ctrl.sv
// Controller: sequences each operation over the datapath.
`timescale 1ns / 1ps

module oat_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  oat_pkg::oat_sts_t  sts,
    output oat_pkg::oat_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_READ_WAIT = 4'd2;
    localparam logic [3:0] S_SHIFT     = 4'd3;
    localparam logic [3:0] S_SHIFT_END = 4'd4;
    localparam logic [3:0] S_INS_WR    = 4'd5;
    localparam logic [3:0] S_SRCH      = 4'd6;
    localparam logic [3:0] S_SRCH_END  = 4'd7;
    localparam logic [3:0] S_REV_RLO   = 4'd8;
    localparam logic [3:0] S_REV_RHI   = 4'd9;
    localparam logic [3:0] S_REV_WLO   = 4'd10;
    localparam logic [3:0] S_REV_END   = 4'd11;
    localparam logic [3:0] S_DONE      = 4'd12;

    logic [3:0] state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_DONE;
                unique case (sts.op)
                    oat_pkg::OP_APPEND:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_full = 1'b1;
                        end
                        else
                        begin
                            cmd.wr_val_cnt = 1'b1;
                            cmd.cnt_inc    = 1'b1;
                        end
                    end
                    oat_pkg::OP_READ:
                    begin
                        if (sts.pos_ge_cnt)
                        begin
                            cmd.set_range = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_pos = 1'b1;
                            state_next = S_READ_WAIT;
                        end
                    end
                    oat_pkg::OP_INSERT:
                    begin
                        if (sts.pos_gt_cnt)
                        begin
                            cmd.set_range = 1'b1;
                        end
                        else if (sts.full)
                        begin
                            cmd.set_full = 1'b1;
                        end
                        else if (sts.pos_ge_cnt)
                        begin
                            // insert exactly at the end: plain append
                            cmd.wr_val_cnt = 1'b1;
                            cmd.cnt_inc    = 1'b1;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_SHIFT;
                        end
                    end
                    oat_pkg::OP_DELETE:
                    begin
                        if (sts.pos_ge_cnt)
                        begin
                            cmd.set_range = 1'b1;
                        end
                        else if (sts.pos_last)
                        begin
                            // last entry: nothing to move down
                            cmd.cnt_dec = 1'b1;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_SHIFT;
                        end
                    end
                    oat_pkg::OP_SEARCH:
                    begin
                        if (!sts.cnt_zero)
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_SRCH;
                        end
                    end
                    oat_pkg::OP_REVERSE:
                    begin
                        if (!sts.cnt_le1)
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_REV_RLO;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_READ_WAIT:
            begin
                cmd.cap_read = 1'b1;
                state_next   = S_DONE;
            end

            // One entry read per cycle; the datapath writes it back in the next cycle
            S_SHIFT:
            begin
                cmd.rd_move = 1'b1;
                if (sts.ptr_at_end)
                begin
                    state_next = S_SHIFT_END;
                end
            end

            S_SHIFT_END:
            begin
                if (sts.op == oat_pkg::OP_INSERT)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end

            S_INS_WR:
            begin
                cmd.wr_val_pos = 1'b1;
                cmd.cnt_inc    = 1'b1;
                state_next     = S_DONE;
            end

            // Stop at the first match or after the last entry
            S_SRCH:
            begin
                if (sts.hit)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_search = 1'b1;
                    if (sts.ptr_at_end)
                    begin
                        state_next = S_SRCH_END;
                    end
                end
            end

            S_SRCH_END:
            begin
                state_next = S_DONE;
            end

            // Lower entry read goes out on the walk pointer
            S_REV_RLO:
            begin
                state_next = S_REV_RHI;
            end

            S_REV_RHI:
            begin
                cmd.rd_hi   = 1'b1;
                cmd.cap_tmp = 1'b1;
                state_next  = S_REV_WLO;
            end

            S_REV_WLO:
            begin
                cmd.wr_swap = 1'b1;
                if (sts.rev_more)
                begin
                    state_next = S_REV_RLO;
                end
                else
                begin
                    state_next = S_REV_END;
                end
            end

            S_REV_END:
            begin
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/ordered_array_table.sv
// Top level of the ordered array table: controller, datapath and channel wiring.
//
//   channel | dir | words carried
//   --------+-----+------------------------------------------------------------
//   req     | in  | opcode, position, value
//   rsp     | out | read_value, found, found_index, entry_count, status
//
// One word is worked on at a time; the entry store has one read and one write port.
// Insert and delete shift the entries past the position one at a time; search reads
// the entries in order up to the first match; reverse swaps pairs from both ends inward.
// A finished result sits in the output register, so the next word is taken while it
// waits; a stalled rsp holds the block in its final step. Reset clears the count;
// the store itself is not cleared.
`timescale 1ns / 1ps

module ordered_array_table (
    input  logic         clk,
    input  logic         rst_n,
    oat_req_if.sink      req,
    oat_rsp_if.source    rsp
);

    oat_pkg::oat_cmd_t cmd;
    oat_pkg::oat_sts_t sts;
    logic              req_ready;

    assign req.ready = req_ready;

    oat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    oat_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (req.opcode),
        .position    (req.position),
        .value       (req.value),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .read_value  (rsp.read_value),
        .found       (rsp.found),
        .found_index (rsp.found_index),
        .entry_count (rsp.entry_count),
        .status      (rsp.status)
    );

endmodule
